// File: src/deq_pkg.sv
// ----------------------------------------------------------------------------
// Deque package
// Shared sizes, types and codes for the double-ended queue and its cells.
// ----------------------------------------------------------------------------
package deq_pkg;

   // Number of cells in the chain. It must be a multiple of GROUP_SIZE.
   localparam int DEPTH = 64;
   // Width of the entry count. It can hold DEPTH itself.
   localparam int CNT_W = $clog2(DEPTH + 1);
   // Cells per group in the first level of the rear select tree.
   localparam int GROUP_SIZE = 8;
   localparam int NUM_GROUPS = DEPTH / GROUP_SIZE;

   typedef logic signed [31:0] word_type;
   typedef logic [CNT_W-1:0]   count_type;
   typedef logic [2:0]         mode_type;
   typedef logic [1:0]         status_type;

   // Value reported for front and rear when the deque is empty.
   localparam word_type EMPTY_MARK = 32'sh8000_0000;

   // Operation codes on the request channel.
   localparam mode_type MODE_PUSH_REAR  = 3'd0;
   localparam mode_type MODE_PUSH_FRONT = 3'd1;
   localparam mode_type MODE_POP_REAR   = 3'd2;
   localparam mode_type MODE_POP_FRONT  = 3'd3;
   localparam mode_type MODE_CLEAR      = 3'd4;
   localparam mode_type MODE_PEEK       = 3'd5;

   // Status codes on the response channel.
   localparam status_type STATUS_DONE  = 2'd0;
   localparam status_type STATUS_FULL  = 2'd1;
   localparam status_type STATUS_EMPTY = 2'd2;

   // Command broadcast to every cell of the chain.
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_PUSH_FRONT,
      CELL_PUSH_REAR,
      CELL_POP_FRONT,
      CELL_POP_REAR,
      CELL_CLEAR
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      word_type    value;
   } cell_ctrl_type;

endpackage

// File: src/deq_cell.sv
// ----------------------------------------------------------------------------
// Deque cell
// One storage cell of the chain. Occupied cells form an unbroken run from
// the front, so each cell decides its move from its own and its neighbors'
// occupancy alone.
// ----------------------------------------------------------------------------
module deq_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  deq_pkg::cell_ctrl_type ctrl,
   input  deq_pkg::word_type      left_data,
   input  logic                   left_valid,
   input  deq_pkg::word_type      right_data,
   input  logic                   right_valid,
   output deq_pkg::word_type      cell_data,
   output logic                   cell_valid,
   output logic                   cell_last
);
   import deq_pkg::*;

   word_type data_ff;
   word_type data_in;
   logic     valid_ff;
   logic     valid_in;

   // Next cell contents for the broadcast command.
   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      case (ctrl.op)
         CELL_PUSH_FRONT: begin
            data_in  = left_data;
            valid_in = left_valid;
         end
         CELL_PUSH_REAR: begin
            if (!valid_ff && left_valid) begin
               data_in  = ctrl.value;
               valid_in = 1'b1;
            end
         end
         CELL_POP_FRONT: begin
            data_in  = right_data;
            valid_in = right_valid;
         end
         CELL_POP_REAR: begin
            if (valid_ff && !right_valid) begin
               valid_in = 1'b0;
            end
         end
         CELL_CLEAR: begin
            valid_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // The occupancy bit is control state; the word itself needs no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign cell_data  = data_ff;
   assign cell_valid = valid_ff;
   assign cell_last  = valid_ff && !right_valid;

endmodule

// File: src/deq_rear_select.sv
// ----------------------------------------------------------------------------
// Deque rear select
// Two-level select of the word in the last occupied cell. The first level
// picks within groups of cells and is registered; the second picks the group.
// ----------------------------------------------------------------------------
module deq_rear_select (
   input  logic                           clock,
   input  logic                           capture,
   input  deq_pkg::word_type              cell_data [deq_pkg::DEPTH],
   input  logic [deq_pkg::DEPTH-1:0]      cell_last,
   output deq_pkg::word_type              rear_value
);
   import deq_pkg::*;

   word_type                grp_data_ff [NUM_GROUPS];
   word_type                grp_data_in [NUM_GROUPS];
   logic [NUM_GROUPS-1:0]   grp_hit_ff;
   logic [NUM_GROUPS-1:0]   grp_hit_in;

   // First level: the last flags are one-hot, so an AND-OR picks the word.
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_hit_in[g]  = |cell_last[g*GROUP_SIZE +: GROUP_SIZE];
         grp_data_in[g] = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            if (cell_last[g*GROUP_SIZE + k]) begin
               grp_data_in[g] = grp_data_in[g] | cell_data[g*GROUP_SIZE + k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         grp_data_ff <= grp_data_in;
         grp_hit_ff  <= grp_hit_in;
      end
   end

   // Second level: pick the one group that holds the last cell.
   always_comb begin
      rear_value = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         if (grp_hit_ff[g]) begin
            rear_value = rear_value | grp_data_ff[g];
         end
      end
   end

endmodule

// File: src/double_ended_queue.sv
// ----------------------------------------------------------------------------
// Double-ended queue
// A deque of signed 32-bit words held in a chain of cells. The front sits in
// the first cell; pushes and pops at the front shift the whole chain by one,
// and pushes and pops at the rear touch only the boundary cell.
//
//   channel   ports                                         direction
//   req       req_valid, req_stall, req_mode, req_value      in
//   rsp       rsp_valid, rsp_stall, rsp_front_value,         out
//             rsp_rear_value, rsp_count, rsp_is_empty,
//             rsp_status
//
// One word is accepted per cycle while the response is not stalled; each
// request gives one response. The path runs through the cell update, the
// registered group picks of the rear select tree and the output register;
// the stages overlap, so the rate is one per cycle unless a stall holds it.
// Reset clears the cell occupancy bits and the entry count; cell words are
// not cleared.
// A stalled response holds the pipeline; req_stall rises once it backs up.
// ----------------------------------------------------------------------------
module double_ended_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  deq_pkg::mode_type     req_mode,
   input  deq_pkg::word_type     req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output deq_pkg::word_type     rsp_front_value,
   output deq_pkg::word_type     rsp_rear_value,
   output deq_pkg::count_type    rsp_count,
   output logic                  rsp_is_empty,
   output deq_pkg::status_type   rsp_status
);
   import deq_pkg::*;

   logic          accept;
   logic          full;
   logic          empty;
   cell_ctrl_type ctrl;
   status_type    status_in;
   count_type     cnt_ff;
   count_type     cnt_in;

   word_type           cell_data  [DEPTH];
   logic [DEPTH-1:0]   cell_valid;
   logic [DEPTH-1:0]   cell_last;
   word_type           rear_value;

   logic          s1_valid_ff;
   count_type     s1_count_ff;
   status_type    s1_status_ff;
   logic          s1_adv;

   logic          s2_valid_ff;
   count_type     s2_count_ff;
   status_type    s2_status_ff;
   word_type      s2_front_ff;
   logic          s2_adv;

   logic          rsp_valid_ff;
   word_type      rsp_front_ff;
   word_type      rsp_rear_ff;
   count_type     rsp_count_ff;
   status_type    rsp_status_ff;

   // Handshake and pipeline advance.
   assign s2_adv    = s2_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign s1_adv    = s1_valid_ff && (!s2_valid_ff || s2_adv);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign accept    = req_valid && !req_stall;

   assign full  = (cnt_ff == count_type'(DEPTH));
   assign empty = (cnt_ff == '0);

   // Decode the request word into a cell command, a status and a new count.
   always_comb begin
      ctrl.op    = CELL_HOLD;
      ctrl.value = req_value;
      status_in  = STATUS_DONE;
      cnt_in     = cnt_ff;
      case (req_mode)
         MODE_PUSH_REAR: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               ctrl.op = CELL_PUSH_REAR;
               cnt_in  = cnt_ff + count_type'(1);
            end
         end
         MODE_PUSH_FRONT: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               ctrl.op = CELL_PUSH_FRONT;
               cnt_in  = cnt_ff + count_type'(1);
            end
         end
         MODE_POP_REAR: begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               ctrl.op = CELL_POP_REAR;
               cnt_in  = cnt_ff - count_type'(1);
            end
         end
         MODE_POP_FRONT: begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               ctrl.op = CELL_POP_FRONT;
               cnt_in  = cnt_ff - count_type'(1);
            end
         end
         MODE_CLEAR: begin
            ctrl.op = CELL_CLEAR;
            cnt_in  = '0;
         end
         MODE_PEEK: begin
         end
         default: begin
         end
      endcase
      if (!accept) begin
         ctrl.op = CELL_HOLD;
         cnt_in  = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // The chain of cells; the ends see the request word and empty neighbors.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      word_type left_data;
      logic     left_valid;
      word_type right_data;
      logic     right_valid;

      if (i == 0) begin : g_first
         assign left_data  = req_value;
         assign left_valid = 1'b1;
      end else begin : g_inner_left
         assign left_data  = cell_data[i-1];
         assign left_valid = cell_valid[i-1];
      end

      if (i == DEPTH - 1) begin : g_final
         assign right_data  = '0;
         assign right_valid = 1'b0;
      end else begin : g_inner_right
         assign right_data  = cell_data[i+1];
         assign right_valid = cell_valid[i+1];
      end

      deq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_data   (left_data),
         .left_valid  (left_valid),
         .right_data  (right_data),
         .right_valid (right_valid),
         .cell_data   (cell_data[i]),
         .cell_valid  (cell_valid[i]),
         .cell_last   (cell_last[i])
      );
   end

   // Rear lookup over the chain, captured as the word leaves the first stage.
   deq_rear_select u_rear_select (
      .clock      (clock),
      .capture    (s1_adv),
      .cell_data  (cell_data),
      .cell_last  (cell_last),
      .rear_value (rear_value)
   );

   // Stage 1: the cells hold the state after the operation.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_count_ff  <= cnt_in;
         s1_status_ff <= status_in;
      end
   end

   // Stage 2: front word and group picks are registered.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         s2_valid_ff <= 1'b1;
      end else if (s2_adv) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_count_ff  <= s1_count_ff;
         s2_status_ff <= s1_status_ff;
         s2_front_ff  <= cell_data[0];
      end
   end

   // Output register; an empty deque reports the empty mark at both ends.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         rsp_count_ff  <= s2_count_ff;
         rsp_status_ff <= s2_status_ff;
         if (s2_count_ff == '0) begin
            rsp_front_ff <= EMPTY_MARK;
            rsp_rear_ff  <= EMPTY_MARK;
         end else begin
            rsp_front_ff <= s2_front_ff;
            rsp_rear_ff  <= rear_value;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_front_value = rsp_front_ff;
   assign rsp_rear_value  = rsp_rear_ff;
   assign rsp_count       = rsp_count_ff;
   assign rsp_is_empty    = (rsp_count_ff == '0);
   assign rsp_status      = rsp_status_ff;

   // The occupied cells always number exactly the entry count.
   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == cnt_ff)
      else $error("cell occupancy does not match the entry count");

   // A non-empty chain has exactly one last cell.
   a_one_last_cell: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) |-> $onehot(cell_last))
      else $error("non-empty chain without a single last cell");

   // The entry count never exceeds the number of cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= count_type'(DEPTH))
      else $error("entry count beyond the chain depth");

   // A dropped push leaves the count unchanged.
   a_drop_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (accept && (status_in == STATUS_FULL)) |=> (cnt_ff == $past(cnt_ff)))
      else $error("dropped push changed the entry count");

endmodule
